/* sv/m4vt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform block.
`default_nettype none

package m4vt_pkg;

    localparam int DIM        = 4;
    localparam int ADDR_W     = 4;
    localparam int IDX_W      = 2;
    localparam int DATA_W     = 32;
    localparam int Q_SHIFT    = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SHIFTED_W  = PROD_W - Q_SHIFT;
    localparam int SUM_W      = SHIFTED_W + 2;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 160;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_XFORM = 2'd2
    } cmd_t;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        elem_t read_value;
        elem_t res_w;
        elem_t res_z;
        elem_t res_y;
        elem_t res_x;
        logic  overflow;
    } result_t;

endpackage

`default_nettype wire

/* sv/m4vt_lane.sv */
// One output column: four Q16.16 products, floor shift and exact sum.
`default_nettype none

module m4vt_lane
    import m4vt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire elem_t vec [DIM],
    input  wire elem_t col [DIM],
    output sum_t       sum
);

    prod_t prod_reg  [DIM];
    prod_t prod_next [DIM];
    sum_t  sum_reg;
    sum_t  sum_next;

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            prod_next[i] = PROD_W'(vec[i]) * PROD_W'(col[i]);
        end
    end

    // arithmetic shift by Q_SHIFT is a floor; keep the top bits, sign-extend
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < DIM; i++) begin
            sum_next = sum_next + sum_t'($signed(prod_reg[i][PROD_W-1:Q_SHIFT]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

/* sv/m4vt_merge.sv */
// Merge of lane sums: saturate, flag overflow, select by command, output and skid registers.
`default_nettype none

module m4vt_merge
    import m4vt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctrl_t                ctrl,
    input  wire elem_t                read_data,
    input  wire sum_t                 sum [DIM],
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata,   // res_x, res_y, res_z, res_w, read_value
    output logic [0:0]                m_tuser,   // overflow
    output logic                      pipe_en
);

    localparam sum_t SAT_MAX = sum_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam sum_t SAT_MIN = -SAT_MAX - sum_t'(1);

    elem_t   sat [DIM];
    logic    ovf [DIM];
    result_t res_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            if (sum[j] > SAT_MAX) begin
                sat[j] = {1'b0, {(DATA_W-1){1'b1}}};
                ovf[j] = 1'b1;
            end else if (sum[j] < SAT_MIN) begin
                sat[j] = {1'b1, {(DATA_W-1){1'b0}}};
                ovf[j] = 1'b1;
            end else begin
                sat[j] = sum[j][DATA_W-1:0];
                ovf[j] = 1'b0;
            end
        end
    end

    always_comb begin
        res_next = '0;
        case (ctrl.cmd)
            CMD_READ: begin
                res_next.read_value = read_data;
            end
            CMD_XFORM: begin
                res_next.res_x    = sat[0];
                res_next.res_y    = sat[1];
                res_next.res_z    = sat[2];
                res_next.res_w    = sat[3];
                res_next.overflow = ovf[0] | ovf[1] | ovf[2] | ovf[3];
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    // pipeline moves whenever the skid stage is free
    assign pipe_en = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (ctrl.valid) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (ctrl.valid) begin
            if (!out_valid_reg || m_tready) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.read_value, out_reg.res_w, out_reg.res_z,
                       out_reg.res_y, out_reg.res_x};
    assign m_tuser  = out_reg.overflow;

endmodule

`default_nettype wire

/* sv/matrix4_vector_transform.sv */
// Top level: matrix store, input stage, four column lanes and the merge stage.
//
//  channel | direction | tdata                                         | tuser
//  s_      | in        | row, col, elem_value, vec_x..vec_w (168 bits) | cmd
//  m_      | out       | res_x..res_w, read_value (160 bits)           | overflow
//
// One beat per cycle while the skid register is empty; each beat lands in the input register,
// then passes the product, sum and output registers in turn.
// The sixteen multipliers sit in four lanes, one per output column.
// Reset clears the matrix to zero and empties the pipeline at once.
// A stalled output fills the skid register; s_tready drops then, and while reset is held.
`default_nettype none

module matrix4_vector_transform
    import m4vt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // row_index, col_index, elem_value,
                                                 // vec_x, vec_y, vec_z, vec_w, zero pad
    input  wire logic [CMD_W-1:0]     s_tuser,   // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // res_x, res_y, res_z, res_w, read_value
    output logic [0:0]                m_tuser    // overflow
);

    logic              pipe_en;
    logic              accept;
    cmd_t              in_cmd;
    logic [ADDR_W-1:0] in_addr;
    elem_t             in_elem;
    elem_t             in_vec [DIM];

    elem_t             mat_reg [DIM*DIM];
    ctrl_t             s0_ctrl_reg;
    ctrl_t             s1_ctrl_reg;
    ctrl_t             s2_ctrl_reg;
    logic [ADDR_W-1:0] s0_addr_reg;
    elem_t             s0_vec_reg [DIM];
    elem_t             s1_read_reg;
    elem_t             s2_read_reg;
    elem_t             col [DIM][DIM];
    sum_t              lane_sum [DIM];

    assign s_tready = pipe_en && aresetn;
    assign accept   = s_tvalid && s_tready;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_addr   = {s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]};
    assign in_elem   = s_tdata[2*IDX_W +: DATA_W];
    assign in_vec[0] = s_tdata[2*IDX_W + DATA_W   +: DATA_W];
    assign in_vec[1] = s_tdata[2*IDX_W + 2*DATA_W +: DATA_W];
    assign in_vec[2] = s_tdata[2*IDX_W + 3*DATA_W +: DATA_W];
    assign in_vec[3] = s_tdata[2*IDX_W + 4*DATA_W +: DATA_W];

    // writes land at accept time, so items already in flight see the older matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIM*DIM; k++) begin
                mat_reg[k] <= '0;
            end
        end else if (accept && in_cmd == CMD_WRITE) begin
            mat_reg[in_addr] <= in_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_ctrl_reg <= '0;
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end else if (pipe_en) begin
            s0_ctrl_reg <= '{valid: accept, cmd: in_cmd};
            s1_ctrl_reg <= s0_ctrl_reg;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_addr_reg <= in_addr;
            s0_vec_reg  <= in_vec;
            s1_read_reg <= mat_reg[s0_addr_reg];
            s2_read_reg <= s1_read_reg;
        end
    end

    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            for (int i = 0; i < DIM; i++) begin
                col[j][i] = mat_reg[i*DIM + j];
            end
        end
    end

    for (genvar j = 0; j < DIM; j++) begin : g_lane
        m4vt_lane u_lane (
            .aclk (aclk),
            .en   (pipe_en),
            .vec  (s0_vec_reg),
            .col  (col[j]),
            .sum  (lane_sum[j])
        );
    end

    m4vt_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (s2_ctrl_reg),
        .read_data (s2_read_reg),
        .sum       (lane_sum),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .pipe_en   (pipe_en)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_matrix4_vector_transform.sv */
// Testbench for the 4x4 Q16.16 matrix-vector transform: directed table, random stream, checks.
`timescale 1ns / 1ps

module tb_matrix4_vector_transform;
    import m4vt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int      RANDOM_ITEMS = 1650;
    localparam int      PAUSE_AT     = 800;
    localparam int      DRAIN_CYCLES = 24;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam longint  SAT_HI       = 64'sd2147483647;
    localparam longint  SAT_LO       = -64'sd2147483648;
    localparam elem_t   Q_MAX        = 32'sh7FFFFFFF;
    localparam elem_t   Q_MIN        = 32'sh80000000;
    localparam elem_t   Q_ONE        = 32'sh00010000;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        elem_t                 elem;
        logic [4*DATA_W-1:0]   vec;
        bit                    typed;
        result_t               want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    elem_t      shadow_matrix [DIM*DIM];
    result_t    awaited_results [$];
    stim_row_t  directed_rows [$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         stall_mode = 0;
    int         mode_left = 0;

    matrix4_vector_transform u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [4*DATA_W-1:0] vec4(elem_t x, elem_t y, elem_t z, elem_t w);
        return {w, z, y, x};
    endfunction

    function automatic result_t make_result(elem_t rx, elem_t ry, elem_t rz, elem_t rw,
                                            elem_t rv, logic ovf);
        result_t r;
        r.res_x      = rx;
        r.res_y      = ry;
        r.res_z      = rz;
        r.res_w      = rw;
        r.read_value = rv;
        r.overflow   = ovf;
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, elem_t elem,
                                         logic [4*DATA_W-1:0] vec, bit typed, result_t want);
        stim_row_t s;
        s.cmd   = cmd;
        s.row   = row;
        s.col   = col;
        s.elem  = elem;
        s.vec   = vec;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // Row-vector times matrix with floor shift and 32-bit saturation; also updates the store.
    function automatic result_t apply_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                              logic [IDX_W-1:0] col, elem_t elem,
                                              logic [4*DATA_W-1:0] vec);
        result_t r;
        longint  acc;
        longint  prod;
        elem_t   lane [DIM];
        logic    ovf;
        r   = '0;
        ovf = 1'b0;
        case (cmd)
            CMD_WRITE: shadow_matrix[{row, col}] = elem;
            CMD_READ:  r.read_value = shadow_matrix[{row, col}];
            CMD_XFORM: begin
                for (int j = 0; j < DIM; j++) begin
                    acc = 0;
                    for (int i = 0; i < DIM; i++) begin
                        prod = longint'(elem_t'(vec[i*DATA_W +: DATA_W]))
                             * longint'(shadow_matrix[i*DIM + j]);
                        acc += prod >>> Q_SHIFT;
                    end
                    if (acc > SAT_HI) begin
                        acc = SAT_HI;
                        ovf = 1'b1;
                    end else if (acc < SAT_LO) begin
                        acc = SAT_LO;
                        ovf = 1'b1;
                    end
                    lane[j] = acc[DATA_W-1:0];
                end
                r = make_result(lane[0], lane[1], lane[2], lane[3], '0, ovf);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mix full-range, small (about +/-2.0) and corner values so sums both saturate and not.
    function automatic elem_t rand_value();
        elem_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6, 7: v = elem_t'(int'($urandom_range(0, 262144)) - 131072);
            default: begin
                case ($urandom_range(0, 5))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = -32'sd1;
                    4: v = Q_ONE;
                    default: v = -Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, elem_t elem, logic [4*DATA_W-1:0] vec,
                             bit typed, result_t want);
        result_t pred;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, vec, elem, col, row};
        do @(posedge aclk); while (!s_tready);
        pred = apply_command(cmd, row, col, elem, vec);
        awaited_results.push_back(typed ? want : pred);
    endtask

    task automatic sender_gap(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_random(logic [CMD_W-1:0] cmd);
        send_item(cmd, IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                  rand_value(),
                  vec4(rand_value(), rand_value(), rand_value(), rand_value()), 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: switch between always ready, random stalls and a sparse fixed pattern.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            mode_left  <= $urandom_range(20, 120);
            stall_mode <= $urandom_range(0, 2);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 6);
            default: m_tready <= (cycle_count % 4 == 0);
        endcase
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h / %b", $realtime,
                         m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("res_x", want.res_x, m_tdata[31:0]);
                check_field("res_y", want.res_y, m_tdata[63:32]);
                check_field("res_z", want.res_z, m_tdata[95:64]);
                check_field("res_w", want.res_w, m_tdata[127:96]);
                check_field("read_value", want.read_value, m_tdata[159:128]);
                check_field("overflow", {31'b0, want.overflow}, {31'b0, m_tuser[0]});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $realtime,
                     awaited_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t s;
        result_t   zero_res;
        elem_t     ld_val;
        int        sent;
        int        burst;
        int        pick;
        bit        paused;

        zero_res = '0;
        sent     = 0;
        paused   = 1'b0;
        for (int k = 0; k < DIM*DIM; k++) shadow_matrix[k] = '0;

        // Typed rows: reset contents, saturation at both ends, unused command.
        directed_rows.push_back(mk_row(CMD_READ, 0, 0, Q_MAX, '0, 1, zero_res));
        directed_rows.push_back(mk_row(CMD_READ, 3, 3, '0, '1, 1, zero_res));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0,
                                       vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1, zero_res));
        for (int r = 0; r < DIM; r++)
            directed_rows.push_back(mk_row(CMD_WRITE, IDX_W'(r), 0, Q_MAX, '1, 1, zero_res));
        directed_rows.push_back(mk_row(CMD_READ, 0, 0, '0, '0, 1,
                                       make_result('0, '0, '0, '0, Q_MAX, 1'b0)));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0,
                                       vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1,
                                       make_result(Q_MAX, '0, '0, '0, '0, 1'b1)));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0,
                                       vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1,
                                       make_result(Q_MIN, '0, '0, '0, '0, 1'b1)));
        directed_rows.push_back(mk_row(CMD_WRITE, 3, 3, Q_MIN, '0, 1, zero_res));
        directed_rows.push_back(mk_row(CMD_READ, 3, 3, '0, '0, 1,
                                       make_result('0, '0, '0, '0, Q_MIN, 1'b0)));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0, vec4('0, '0, '0, Q_MIN), 1,
                                       make_result(Q_MIN, '0, '0, Q_MAX, '0, 1'b1)));
        directed_rows.push_back(mk_row(CMD_UNUSED, 3, 3, '1, '1, 1, zero_res));
        // Predicted rows: ordinary values and floor rounding of negative products.
        directed_rows.push_back(mk_row(CMD_WRITE, 1, 2, Q_ONE, '0, 0, zero_res));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0,
                                       vec4(32'sh00010000, 32'sh00020000, -32'sh00030000,
                                            32'sh00008000), 0, zero_res));
        directed_rows.push_back(mk_row(CMD_WRITE, 2, 1, -32'sh00018000, '0, 0, zero_res));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0,
                                       vec4(-32'sd1, -32'sd1, -32'sd1, 32'sd1), 0, zero_res));
        directed_rows.push_back(mk_row(CMD_READ, 1, 2, '0, '0, 0, zero_res));
        directed_rows.push_back(mk_row(CMD_READ, 2, 1, '0, '0, 0, zero_res));
        directed_rows.push_back(mk_row(CMD_XFORM, 0, 0, '0, '0, 0, zero_res));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            s = directed_rows[k];
            send_item(s.cmd, s.row, s.col, s.elem, s.vec, s.typed, s.want);
            if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 3));
        end

        while (sent < RANDOM_ITEMS) begin
            if (!paused && sent >= PAUSE_AT) begin
                // Hold off until the pipeline has drained completely.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (awaited_results.size() != 0);
            end
            if ($urandom_range(0, 7) == 0) begin
                // Load a fresh small-valued matrix, then stream vectors through it.
                for (int k = 0; k < DIM*DIM; k++) begin
                    ld_val = elem_t'(int'($urandom_range(0, 262144)) - 131072);
                    send_item(CMD_WRITE, IDX_W'(k / DIM), IDX_W'(k % DIM), ld_val,
                              (4*DATA_W)'($urandom), 1'b0, '0);
                end
                burst = $urandom_range(4, 16);
                for (int k = 0; k < burst; k++) send_random(CMD_XFORM);
                sent += DIM*DIM + burst;
            end else begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 6)       send_random(CMD_WRITE);
                    else if (pick < 11) send_random(CMD_READ);
                    else if (pick < 19) send_random(CMD_XFORM);
                    else                send_random(CMD_UNUSED);
                end
                sent += burst;
            end
            if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 8));
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
